// File: src/rpi_pkg.sv
// Shared definitions for the ray / parallelogram intersection pipeline.
// Depends on nothing; imported by rpi_geom and the top level.
`default_nettype none
package rpi_pkg;

	localparam int FRAC_BITS_DEF  = 10;
	localparam int COORD_BITS_DEF = 20;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_U   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_V   = 2'd2;

	// per-beat control that travels beside the payload
	typedef struct packed {
		logic valid;
		logic hit;
	} rpi_ctl_t;

endpackage
`default_nettype wire

// File: src/ray_parallelogram_intersect.sv
// Ray / parallelogram intersection, fully pipelined, one ray per clock.
// Default coordinate format: Q10.10 (COORD_BITS 20, FRAC_BITS 10).
// Throughput: one beat per cycle, always; busy is held low, and the
// receiver takes each result in its done cycle.
// Reset (arst_n low, asynchronous): clears the valid chain and all three
// shape registers; results in flight are dropped.
`default_nettype none
module ray_parallelogram_intersect import rpi_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// ray channel
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] origin_x,
	input  wire logic signed [COORD_BITS-1:0] origin_y,
	input  wire logic signed [COORD_BITS-1:0] origin_z,
	input  wire logic signed [COORD_BITS-1:0] dir_x,
	input  wire logic signed [COORD_BITS-1:0] dir_y,
	input  wire logic signed [COORD_BITS-1:0] dir_z,
	// shape registers
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [3*COORD_BITS-1:0]      cfg_wdata,
	// result channel
	output logic                              done,
	output logic                              hit,
	output logic signed [COORD_BITS-1:0]      impact_x,
	output logic signed [COORD_BITS-1:0]      impact_y,
	output logic signed [COORD_BITS-1:0]      impact_z,
	output logic [COORD_BITS-2:0]             ray_distance
);
	localparam int CB = COORD_BITS;
	localparam int FB = FRAC_BITS;
	localparam int DW = 3 * CB + 4;        // signed dot-product width
	localparam int MW = DW - 1;            // magnitude width
	localparam int LO = MW / 2;            // low slice of num for the split multiply
	localparam int HI = MW - LO;
	localparam int NW = MW + ((CB > FB) ? CB : FB);
	localparam int QB = CB + 2;            // quotient bits kept by the dividers
	localparam int PB = CB + 3;            // impact sum width
	localparam logic [QB-1:0] OFF_LIM  = QB'(1) << (CB + 1);
	localparam logic [QB-1:0] DIST_LIM = (QB'(1) << (CB - 1)) - QB'(1);

	// the pipeline never refuses a ray
	assign busy = 1'b0;

	// shape registers
	logic [3*CB-1:0] corner_a_q, edge_u_q, edge_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_a_q <= '0;
			edge_u_q   <= '0;
			edge_v_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CORNER_A: corner_a_q <= cfg_wdata;
				REG_EDGE_U:   edge_u_q   <= cfg_wdata;
				REG_EDGE_V:   edge_v_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// geometry: den = d.n, num = -(e.n), hit decision (7 stages)
	logic signed [CB-1:0] o_in [3], d_in [3], o_g [3], d_g [3];
	rpi_ctl_t             ctl_g;
	logic [MW-1:0]        den_g, num_g;

	assign o_in[0] = origin_x;
	assign o_in[1] = origin_y;
	assign o_in[2] = origin_z;
	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	rpi_geom #(.CB(CB)) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.o_in     (o_in),
		.d_in     (d_in),
		.corner_a (corner_a_q),
		.edge_u   (edge_u_q),
		.edge_v   (edge_v_q),
		.ctl_out  (ctl_g),
		.den_mag  (den_g),
		.num_mag  (num_g),
		.o_out    (o_g),
		.d_out    (d_g)
	);

	// p1: num * |d| as two partial products per axis
	logic [CB-1:0]    dm [3];
	logic [LO+CB-1:0] pl_p1 [3];
	logic [HI+CB-1:0] ph_p1 [3];
	logic [MW-1:0]    den_p1, num_p1, den_p2;
	logic [NW-1:0]    n_p2 [3];
	logic [NW-1:0]    nt_p2;
	rpi_ctl_t         ctl_p1, ctl_p2;
	logic signed [CB-1:0] o_p1 [3], o_p2 [3];
	logic             dn_p1 [3], dn_p2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			dm[i] = d_g[i][CB-1] ? CB'(-d_g[i]) : CB'(d_g[i]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pl_p1[i] <= (LO+CB)'(num_g[LO-1:0]) * (LO+CB)'(dm[i]);
			ph_p1[i] <= (HI+CB)'(num_g[MW-1:LO]) * (HI+CB)'(dm[i]);
			o_p1[i]  <= o_g[i];
			dn_p1[i] <= d_g[i][CB-1];
			// p2: recombine
			n_p2[i]  <= (NW'(ph_p1[i]) << LO) + NW'(pl_p1[i]);
			o_p2[i]  <= o_p1[i];
			dn_p2[i] <= dn_p1[i];
		end
		den_p1 <= den_g;
		num_p1 <= num_g;
		den_p2 <= den_p1;
		nt_p2  <= NW'(num_p1) << FB;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_p1 <= '0;
			ctl_p2 <= '0;
		end else begin
			ctl_p1 <= ctl_g;
			ctl_p2 <= ctl_p1;
		end
	end

	// dividers: offset per axis and distance, QB stages each
	logic [QB-1:0] q_ax [3];
	logic          sat_ax [3];
	logic [QB-1:0] q_t;
	logic          sat_t;

	for (genvar i = 0; i < 3; i++) begin : g_axis
		rpi_div #(.NW(NW), .MW(MW), .QB(QB)) u_div (
			.clk (clk),
			.num (n_p2[i]),
			.den (den_p2),
			.quo (q_ax[i]),
			.sat (sat_ax[i])
		);
	end

	rpi_div #(.NW(NW), .MW(MW), .QB(QB)) u_div_t (
		.clk (clk),
		.num (nt_p2),
		.den (den_p2),
		.quo (q_t),
		.sat (sat_t)
	);

	// sideband delay matched to the divider depth
	rpi_ctl_t             ctl_dl [QB];
	logic signed [CB-1:0] o_dl [QB][3];
	logic                 dn_dl [QB][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QB; k++)
				ctl_dl[k] <= '0;
		end else begin
			ctl_dl[0] <= ctl_p2;
			for (int k = 1; k < QB; k++)
				ctl_dl[k] <= ctl_dl[k-1];
		end
	end

	always_ff @(posedge clk) begin
		o_dl[0]  <= o_p2;
		dn_dl[0] <= dn_p2;
		for (int k = 1; k < QB; k++) begin
			o_dl[k]  <= o_dl[k-1];
			dn_dl[k] <= dn_dl[k-1];
		end
	end

	// output stage: saturate offsets and distance, add offsets to origin, clamp
	rpi_ctl_t             ctl_f;
	logic [QB-1:0]        off [3];
	logic signed [PB-1:0] psum [3];
	logic [CB-1:0]        imp [3];
	logic [QB-1:0]        rdist;

	assign ctl_f = ctl_dl[QB-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i]  = (sat_ax[i] || q_ax[i] > OFF_LIM) ? OFF_LIM : q_ax[i];
			psum[i] = dn_dl[QB-1][i]
				? PB'(o_dl[QB-1][i]) - $signed({1'b0, off[i]})
				: PB'(o_dl[QB-1][i]) + $signed({1'b0, off[i]});
			if (psum[i][PB-1:CB-1] == '0 || psum[i][PB-1:CB-1] == '1)
				imp[i] = psum[i][CB-1:0];
			else if (psum[i][PB-1])
				imp[i] = {1'b1, {(CB-1){1'b0}}};
			else
				imp[i] = {1'b0, {(CB-1){1'b1}}};
		end
		rdist = (sat_t || q_t > DIST_LIM) ? DIST_LIM : q_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			hit  <= 1'b0;
		end else begin
			done <= ctl_f.valid;
			hit  <= ctl_f.hit;
		end
	end

	// fields are zero on a miss
	always_ff @(posedge clk) begin
		impact_x     <= ctl_f.hit ? $signed(imp[0]) : '0;
		impact_y     <= ctl_f.hit ? $signed(imp[1]) : '0;
		impact_z     <= ctl_f.hit ? $signed(imp[2]) : '0;
		ray_distance <= ctl_f.hit ? rdist[CB-2:0] : '0;
	end

endmodule
`default_nettype wire

// File: src/rpi_geom.sv
// Geometry front end: cross products, dot products, sign fix and hit test.
// Seven register stages; uses rpi_pkg for the control struct.
`default_nettype none
module rpi_geom import rpi_pkg::*; #(
	parameter int CB = COORD_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic signed [CB-1:0] o_in [3],
	input  wire logic signed [CB-1:0] d_in [3],
	input  wire logic [3*CB-1:0]     corner_a,
	input  wire logic [3*CB-1:0]     edge_u,
	input  wire logic [3*CB-1:0]     edge_v,
	output rpi_ctl_t                 ctl_out,
	output logic [3*CB+2:0]          den_mag,
	output logic [3*CB+2:0]          num_mag,
	output logic signed [CB-1:0]     o_out [3],
	output logic signed [CB-1:0]     d_out [3]
);
	localparam int EW  = CB + 1;
	localparam int PW  = 2 * CB;
	localparam int NW2 = 2 * CB + 1;
	localparam int QPW = 2 * CB + 1;
	localparam int QW  = 2 * CB + 2;
	localparam int DW  = 3 * CB + 4;
	localparam int MW  = DW - 1;

	logic signed [CB-1:0] a [3];
	logic signed [CB-1:0] u [3];
	logic signed [CB-1:0] v [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(corner_a[i*CB +: CB]);
			u[i] = $signed(edge_u[i*CB +: CB]);
			v[i] = $signed(edge_v[i*CB +: CB]);
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	rpi_ctl_t ctl_s7;

	logic signed [CB-1:0]  o_s1 [3], o_s2 [3], o_s3 [3], o_s4 [3], o_s5 [3], o_s6 [3], o_s7 [3];
	logic signed [CB-1:0]  d_s1 [3], d_s2 [3], d_s3 [3], d_s4 [3], d_s5 [3], d_s6 [3], d_s7 [3];
	logic signed [EW-1:0]  e_s1 [3], e_s2 [3];
	logic signed [PW-1:0]  np_s1 [6];
	logic signed [NW2-1:0] n_s2 [3];
	logic signed [QPW-1:0] qp_s2 [6];
	logic signed [QW-1:0]  q_s3 [3];
	logic signed [DW-1:0]  dn_s3 [3], en_s3 [3];
	logic signed [DW-1:0]  den_s4, num_s4;
	logic signed [DW-1:0]  sp_s4 [3], rp_s4 [3];
	logic signed [DW-1:0]  den_s5, num_s5, s_s5, r_s5;
	logic signed [DW-1:0]  den_s6, num_s6, s_s6, r_s6;
	logic [MW-1:0]         den_s7, num_s7;
	logic                  neg5;
	logic                  hit6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			ctl_s7 <= '0;
		end else begin
			v_s1         <= in_valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			v_s5         <= v_s4;
			v_s6         <= v_s5;
			ctl_s7.valid <= v_s6;
			ctl_s7.hit   <= v_s6 & hit6;
		end
	end

	assign neg5 = den_s5[DW-1];

	// hit: nonparallel, t > 0, both edge parameters in [0,1]
	assign hit6 = (den_s6 != '0) && !num_s6[DW-1] && (num_s6 != '0)
		&& !s_s6[DW-1] && (s_s6 <= den_s6)
		&& !r_s6[DW-1] && (r_s6 <= den_s6);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			o_s1[i] <= o_in[i];
			d_s1[i] <= d_in[i];
			e_s1[i] <= EW'(o_in[i]) - EW'(a[i]);
			o_s2[i] <= o_s1[i];
			d_s2[i] <= d_s1[i];
			e_s2[i] <= e_s1[i];
			o_s3[i] <= o_s2[i];
			d_s3[i] <= d_s2[i];
			o_s4[i] <= o_s3[i];
			d_s4[i] <= d_s3[i];
			o_s5[i] <= o_s4[i];
			d_s5[i] <= d_s4[i];
			o_s6[i] <= o_s5[i];
			d_s6[i] <= d_s5[i];
			o_s7[i] <= o_s6[i];
			d_s7[i] <= d_s6[i];
		end
		// n = u x v, products
		np_s1[0] <= PW'(u[1]) * PW'(v[2]);
		np_s1[1] <= PW'(u[2]) * PW'(v[1]);
		np_s1[2] <= PW'(u[2]) * PW'(v[0]);
		np_s1[3] <= PW'(u[0]) * PW'(v[2]);
		np_s1[4] <= PW'(u[0]) * PW'(v[1]);
		np_s1[5] <= PW'(u[1]) * PW'(v[0]);
		for (int i = 0; i < 3; i++)
			n_s2[i] <= NW2'(np_s1[2*i]) - NW2'(np_s1[2*i+1]);
		// q = d x e, products
		qp_s2[0] <= QPW'(d_s1[1]) * QPW'(e_s1[2]);
		qp_s2[1] <= QPW'(d_s1[2]) * QPW'(e_s1[1]);
		qp_s2[2] <= QPW'(d_s1[2]) * QPW'(e_s1[0]);
		qp_s2[3] <= QPW'(d_s1[0]) * QPW'(e_s1[2]);
		qp_s2[4] <= QPW'(d_s1[0]) * QPW'(e_s1[1]);
		qp_s2[5] <= QPW'(d_s1[1]) * QPW'(e_s1[0]);
		for (int i = 0; i < 3; i++) begin
			q_s3[i]  <= QW'(qp_s2[2*i]) - QW'(qp_s2[2*i+1]);
			dn_s3[i] <= DW'(d_s2[i]) * DW'(n_s2[i]);
			en_s3[i] <= DW'(e_s2[i]) * DW'(n_s2[i]);
			sp_s4[i] <= DW'(v[i]) * DW'(q_s3[i]);
			rp_s4[i] <= DW'(u[i]) * DW'(q_s3[i]);
		end
		den_s4 <= dn_s3[0] + dn_s3[1] + dn_s3[2];
		num_s4 <= -(en_s3[0] + en_s3[1] + en_s3[2]);
		den_s5 <= den_s4;
		num_s5 <= num_s4;
		s_s5   <= sp_s4[0] + sp_s4[1] + sp_s4[2];
		r_s5   <= -(rp_s4[0] + rp_s4[1] + rp_s4[2]);
		// make the denominator positive
		den_s6 <= neg5 ? -den_s5 : den_s5;
		num_s6 <= neg5 ? -num_s5 : num_s5;
		s_s6   <= neg5 ? -s_s5 : s_s5;
		r_s6   <= neg5 ? -r_s5 : r_s5;
		den_s7 <= den_s6[MW-1:0];
		num_s7 <= num_s6[MW-1:0];
	end

	assign ctl_out = ctl_s7;
	assign den_mag = den_s7;
	assign num_mag = num_s7;
	assign o_out   = o_s7;
	assign d_out   = d_s7;

endmodule
`default_nettype wire

// File: src/rpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Standalone; instantiated by the top level.
`default_nettype none
module rpi_div #(
	parameter int NW = 84,
	parameter int MW = 63,
	parameter int QB = 22
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [MW-1:0] den,
	output logic [QB-1:0]      quo,
	output logic               sat
);
	localparam int RW = NW + QB + 1;

	logic [RW-1:0] rem_r [QB];
	logic [MW-1:0] den_r [QB];
	logic [QB-1:0] quo_r [QB];
	logic          sat_r [QB];
	logic          sat0;

	assign sat0 = RW'(num) >= (RW'(den) << QB);

	for (genvar j = 0; j < QB; j++) begin : g_step
		logic [RW-1:0] rem_i;
		logic [MW-1:0] den_i;
		logic [QB-1:0] quo_i;
		logic          sat_i;
		logic [RW-1:0] sub;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_i = RW'(num);
			assign den_i = den;
			assign quo_i = '0;
			assign sat_i = sat0;
		end else begin : g_next
			assign rem_i = rem_r[j-1];
			assign den_i = den_r[j-1];
			assign quo_i = quo_r[j-1];
			assign sat_i = sat_r[j-1];
		end

		assign sub = RW'(den_i) << (QB - 1 - j);
		assign ge  = rem_i >= sub;

		always_ff @(posedge clk) begin
			rem_r[j] <= ge ? rem_i - sub : rem_i;
			den_r[j] <= den_i;
			quo_r[j] <= {quo_i[QB-2:0], ge};
			sat_r[j] <= sat_i;
		end
	end

	assign quo = quo_r[QB-1];
	assign sat = sat_r[QB-1];

endmodule
`default_nettype wire
